### hdl/touch_tap_lamp_controller_assert.svh
// Assertion macros shared by the lamp controller RTL.
`ifndef TOUCH_TAP_LAMP_CONTROLLER_ASSERT_SVH
`define TOUCH_TAP_LAMP_CONTROLLER_ASSERT_SVH

// Check a property on every clock edge, masked while reset is high.
`define TTL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TTL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/ttl_pkg.sv
// Types, constants and helper functions of the touch and tap lamp controller.
`default_nettype none

package ttl_pkg;

   // Register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_TOUCH_THRESHOLD  = 3'd0,
      REG_TAP_THRESHOLD    = 3'd1,
      REG_LIGHT_THRESHOLD  = 3'd2,
      REG_MAX_LEVEL        = 3'd3,
      REG_TOUCH_HOLDOFF_MS = 3'd4,
      REG_DOUBLE_TAP_MS    = 3'd5,
      REG_CALIB_WINDOW_MS  = 3'd6
   } csr_index_type;

   localparam logic [15:0] TOUCH_THRESHOLD_RST  = 16'd60;
   localparam logic [9:0]  TAP_THRESHOLD_RST    = 10'd4;
   localparam logic [9:0]  LIGHT_THRESHOLD_RST  = 10'd700;
   localparam logic [7:0]  MAX_LEVEL_RST        = 8'd150;
   localparam logic [15:0] TOUCH_HOLDOFF_MS_RST = 16'd500;
   localparam logic [15:0] DOUBLE_TAP_MS_RST    = 16'd500;
   localparam logic [15:0] CALIB_WINDOW_MS_RST  = 16'd2000;

   // Latch refresh period in ticks
   localparam int REFRESH_TICKS_DEF = 50;

   // Brightness bands
   localparam logic [9:0] LIGHT_BAND_LOW  = 10'd590;
   localparam logic [9:0] LIGHT_BAND_MID  = 10'd750;
   localparam logic [7:0] LEVEL_DROP_LOW  = 8'd100;
   localparam logic [7:0] LEVEL_DROP_MID  = 8'd50;

   // Colours
   typedef enum logic [2:0] {
      COLOUR_WHITE   = 3'd0,
      COLOUR_RED     = 3'd1,
      COLOUR_GREEN   = 3'd2,
      COLOUR_BLUE    = 3'd3,
      COLOUR_YELLOW  = 3'd4,
      COLOUR_CYAN    = 3'd5,
      COLOUR_MAGENTA = 3'd6
   } colour_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Advance through the seven colours, wrapping after magenta.
   function automatic logic [2:0] next_colour(logic [2:0] c);
      logic [2:0] n;
      if (c == COLOUR_MAGENTA) n = COLOUR_WHITE;
      else                     n = c + 3'd1;
      return n;
   endfunction

   // Drive levels for a colour: used channels get the brightness, others 0.
   function automatic rgb_type colour_levels(logic [2:0] c, logic [7:0] b);
      logic [2:0] m;
      rgb_type    r;
      case (c)
         COLOUR_WHITE:   m = 3'b111;
         COLOUR_RED:     m = 3'b001;
         COLOUR_GREEN:   m = 3'b010;
         COLOUR_BLUE:    m = 3'b100;
         COLOUR_YELLOW:  m = 3'b011;
         COLOUR_CYAN:    m = 3'b110;
         COLOUR_MAGENTA: m = 3'b101;
         default:        m = 3'b000;
      endcase
      r.red   = m[0] ? b : 8'd0;
      r.green = m[1] ? b : 8'd0;
      r.blue  = m[2] ? b : 8'd0;
      return r;
   endfunction

   // Pick the brightness band from the light level, saturating at 0.
   function automatic logic [7:0] band_level(logic [9:0] light, logic [7:0] maxl);
      logic [7:0] v;
      if (light <= LIGHT_BAND_LOW)
         v = (maxl >= LEVEL_DROP_LOW) ? maxl - LEVEL_DROP_LOW : 8'd0;
      else if (light <= LIGHT_BAND_MID)
         v = (maxl >= LEVEL_DROP_MID) ? maxl - LEVEL_DROP_MID : 8'd0;
      else
         v = maxl;
      return v;
   endfunction

endpackage

`default_nettype wire

### hdl/touch_tap_lamp_controller.sv
// Top level of the touch and tap lamp controller.
`default_nettype none

// Touch and tap lamp controller. Every request word is one sensor tick
// (timestamp in ms, capacitive, light and piezo readings) and produces exactly
// one response word with the latched RGB drive levels, lamp and auto flags,
// colour index, blink request and calibration flag. Timestamps below
// calib_window_ms only raise the touch and tap baselines (running maxima of
// the current sample). After that a touch above baseline plus threshold,
// outside the holdoff, toggles the lamp; a single tap advances the colour, a
// double tap toggles auto mode, asks for 3 minus auto blinks and turns the
// lamp off; in auto mode the light level switches the lamp; the latch is
// reloaded every REFRESH_TICKS ticks while the lamp is on. Rate: one word per
// clock while the response side takes words. The whole tick update is a single
// pass of compare and select logic from the accepted request to the state and
// the response register, and the request side stays ready as long as the
// response register is empty or is being drained in the same cycle. Registers
// sit at byte address 4*index on the APB-style port. The user must write them
// only while the block is idle (not enforced); reads return the stored value.
module touch_tap_lamp_controller #(
   parameter int REFRESH_TICKS = ttl_pkg::REFRESH_TICKS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // request words
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [31:0]                     req_now_ms,
   input  wire  [15:0]                     req_touch_sample,
   input  wire  [9:0]                      req_light_sample,
   input  wire  [9:0]                      req_tap_sample,
   // response words
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [7:0]                      rsp_red_level,
   output logic [7:0]                      rsp_green_level,
   output logic [7:0]                      rsp_blue_level,
   output logic                            rsp_lamp_on,
   output logic                            rsp_auto_on,
   output logic [2:0]                      rsp_colour_index,
   output logic [1:0]                      rsp_blink_request,
   output logic                            rsp_is_calibrated,
   // register port
   input  wire                             psel,
   input  wire                             penable,
   input  wire                             pwrite,
   input  wire  [ttl_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire  [ttl_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ttl_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   import ttl_pkg::*;

`include "touch_tap_lamp_controller_assert.svh"

   // Counter wide enough to hold the refresh limit itself
   localparam int RT_W = $clog2(REFRESH_TICKS + 1);
   localparam logic [RT_W-1:0] RT_LIMIT = RT_W'(REFRESH_TICKS);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [15:0] touch_thr_ff;
   logic [9:0]  tap_thr_ff;
   logic [9:0]  light_thr_ff;
   logic [7:0]  max_level_ff;
   logic [15:0] holdoff_ff;
   logic [15:0] double_tap_ff;
   logic [15:0] calib_win_ff;

   logic          csr_write;
   csr_index_type csr_idx;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   // word address; byte offset bits are ignored
   assign csr_idx   = csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_thr_ff  <= TOUCH_THRESHOLD_RST;
         tap_thr_ff    <= TAP_THRESHOLD_RST;
         light_thr_ff  <= LIGHT_THRESHOLD_RST;
         max_level_ff  <= MAX_LEVEL_RST;
         holdoff_ff    <= TOUCH_HOLDOFF_MS_RST;
         double_tap_ff <= DOUBLE_TAP_MS_RST;
         calib_win_ff  <= CALIB_WINDOW_MS_RST;
      end else if (csr_write) begin
         case (csr_idx)
            REG_TOUCH_THRESHOLD:  touch_thr_ff  <= pwdata[15:0];
            REG_TAP_THRESHOLD:    tap_thr_ff    <= pwdata[9:0];
            REG_LIGHT_THRESHOLD:  light_thr_ff  <= pwdata[9:0];
            REG_MAX_LEVEL:        max_level_ff  <= pwdata[7:0];
            REG_TOUCH_HOLDOFF_MS: holdoff_ff    <= pwdata[15:0];
            REG_DOUBLE_TAP_MS:    double_tap_ff <= pwdata[15:0];
            REG_CALIB_WINDOW_MS:  calib_win_ff  <= pwdata[15:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TOUCH_THRESHOLD:  prdata = {16'd0, touch_thr_ff};
         REG_TAP_THRESHOLD:    prdata = {22'd0, tap_thr_ff};
         REG_LIGHT_THRESHOLD:  prdata = {22'd0, light_thr_ff};
         REG_MAX_LEVEL:        prdata = {24'd0, max_level_ff};
         REG_TOUCH_HOLDOFF_MS: prdata = {16'd0, holdoff_ff};
         REG_DOUBLE_TAP_MS:    prdata = {16'd0, double_tap_ff};
         REG_CALIB_WINDOW_MS:  prdata = {16'd0, calib_win_ff};
         default:              prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Lamp state
   // ---------------------------------------------------------------------
   logic            on_ff,         on_in;
   logic [2:0]      colour_ff,     colour_in;
   logic            auto_ff,       auto_in;
   logic            calib_ff,      calib_in;
   logic            pending_ff,    pending_in;
   logic [31:0]     last_tap_ff,   last_tap_in;
   logic [31:0]     last_touch_ff, last_touch_in;
   logic [RT_W-1:0] ticks_ff,      ticks_in;
   logic [9:0]      tap_base_ff,   tap_base_in;
   logic [15:0]     touch_base_ff, touch_base_in;
   rgb_type         latch_ff,      latch_in;
   logic [1:0]      blink_in;

   // ---------------------------------------------------------------------
   // Response register and handshake
   // ---------------------------------------------------------------------
   logic       rsp_valid_ff;
   rgb_type    rsp_rgb_ff;
   logic       rsp_on_ff;
   logic       rsp_auto_ff;
   logic [2:0] rsp_colour_ff;
   logic [1:0] rsp_blink_ff;
   logic       rsp_calib_ff;
   logic       req_accept;

   // Take a new word whenever the response slot is free or drains this cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Tick update: calibrate, touch, tap, tap expiry, auto switching, refresh
   // ---------------------------------------------------------------------
   logic        in_window;
   logic [7:0]  bright;
   logic [16:0] touch_limit;
   logic [10:0] tap_limit;
   logic        touch_hit;
   logic        tap_hit;
   logic [31:0] touch_elapsed;
   logic [31:0] tap_elapsed;

   always_comb begin
      touch_base_in = touch_base_ff;
      tap_base_in   = tap_base_ff;
      on_in         = on_ff;
      colour_in     = colour_ff;
      auto_in       = auto_ff;
      pending_in    = pending_ff;
      last_tap_in   = last_tap_ff;
      last_touch_in = last_touch_ff;
      ticks_in      = ticks_ff;
      latch_in      = latch_ff;
      blink_in      = 2'd0;

      // Raise the baselines with the current sample while inside the window.
      in_window = req_now_ms < {16'd0, calib_win_ff};
      if (in_window) begin
         if (req_tap_sample > tap_base_ff)     tap_base_in   = req_tap_sample;
         if (req_touch_sample > touch_base_ff) touch_base_in = req_touch_sample;
      end
      calib_in = calib_ff | !in_window;

      bright = band_level(req_light_sample, max_level_ff);

      // Thresholds are summed one bit wider so they never wrap.
      touch_limit   = {1'b0, touch_base_in} + {1'b0, touch_thr_ff};
      tap_limit     = {1'b0, tap_base_in} + {1'b0, tap_thr_ff};
      touch_hit     = {1'b0, req_touch_sample} > touch_limit;
      tap_hit       = {1'b0, req_tap_sample} > tap_limit;
      touch_elapsed = req_now_ms - last_touch_ff;
      tap_elapsed   = req_now_ms - last_tap_ff;

      if (calib_in) begin
         // touch toggles the lamp once the holdoff has passed
         if (touch_hit && (touch_elapsed > {16'd0, holdoff_ff})) begin
            if (on_in) begin
               on_in    = 1'b0;
               latch_in = '0;
            end else begin
               on_in    = 1'b1;
               latch_in = colour_levels(colour_in, bright);
            end
            last_touch_in = req_now_ms;
         end

         // second tap: double tap inside the window, else a late single tap
         if (tap_hit) begin
            if (pending_in) begin
               pending_in = 1'b0;
               if (tap_elapsed < {16'd0, double_tap_ff}) begin
                  auto_in  = !auto_in;
                  blink_in = auto_in ? 2'd2 : 2'd3;
                  on_in    = 1'b0;
                  latch_in = '0;
               end else begin
                  colour_in = next_colour(colour_in);
                  latch_in  = colour_levels(colour_in, bright);
               end
            end else begin
               pending_in  = 1'b1;
               last_tap_in = req_now_ms;
            end
         end

         // expire a pending tap into a single tap, same tick's time
         if (pending_in && ((req_now_ms - last_tap_in) >= {16'd0, double_tap_ff})) begin
            pending_in = 1'b0;
            colour_in  = next_colour(colour_in);
            latch_in   = colour_levels(colour_in, bright);
         end

         // light level switches the lamp in auto mode; equality holds
         if (auto_in) begin
            if ((req_light_sample < light_thr_ff) && !on_in) begin
               on_in    = 1'b1;
               latch_in = colour_levels(colour_in, bright);
            end else if ((req_light_sample > light_thr_ff) && on_in) begin
               on_in    = 1'b0;
               latch_in = '0;
            end
         end

         // periodic refresh; the count saturates while the lamp is off
         if ((ticks_in >= RT_LIMIT) && on_in) begin
            latch_in = colour_levels(colour_in, bright);
            ticks_in = '0;
         end
         if (ticks_in < RT_LIMIT) ticks_in = ticks_in + RT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff         <= 1'b0;
         colour_ff     <= COLOUR_WHITE;
         auto_ff       <= 1'b0;
         calib_ff      <= 1'b0;
         pending_ff    <= 1'b0;
         last_tap_ff   <= '0;
         last_touch_ff <= '0;
         ticks_ff      <= '0;
         tap_base_ff   <= '0;
         touch_base_ff <= '0;
         latch_ff      <= '0;
      end else if (req_accept) begin
         on_ff         <= on_in;
         colour_ff     <= colour_in;
         auto_ff       <= auto_in;
         calib_ff      <= calib_in;
         pending_ff    <= pending_in;
         last_tap_ff   <= last_tap_in;
         last_touch_ff <= last_touch_in;
         ticks_ff      <= ticks_in;
         tap_base_ff   <= tap_base_in;
         touch_base_ff <= touch_base_in;
         latch_ff      <= latch_in;
      end
   end

   // Response valid: set on accept, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_rgb_ff    <= latch_in;
         rsp_on_ff     <= on_in;
         rsp_auto_ff   <= auto_in;
         rsp_colour_ff <= colour_in;
         rsp_blink_ff  <= blink_in;
         rsp_calib_ff  <= calib_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_level     = rsp_rgb_ff.red;
   assign rsp_green_level   = rsp_rgb_ff.green;
   assign rsp_blue_level    = rsp_rgb_ff.blue;
   assign rsp_lamp_on       = rsp_on_ff;
   assign rsp_auto_on       = rsp_auto_ff;
   assign rsp_colour_index  = rsp_colour_ff;
   assign rsp_blink_request = rsp_blink_ff;
   assign rsp_is_calibrated = rsp_calib_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Two blinks enter auto mode (light may switch the lamp back on at once);
   // three leave it with the lamp dark.
   logic blink_consistent;
   logic lamp_untouched;

   assign blink_consistent = ((rsp_blink_request == 2'd2) && rsp_auto_on) ||
                             ((rsp_blink_request == 2'd3) && !rsp_auto_on && !rsp_lamp_on);
   assign lamp_untouched   = !rsp_lamp_on && !rsp_auto_on && (rsp_blink_request == 2'd0);

   `TTL_ASSERT_ALWAYS(a_reset_empties_rsp, reset |=> !rsp_valid, "response valid after reset")
   `TTL_ASSERT(a_calib_sticks, calib_ff |=> calib_ff, "calibration flag dropped")
   `TTL_ASSERT(a_ready_when_empty, !rsp_valid_ff |-> req_ready, "not ready with empty slot")
   `TTL_ASSERT(a_blink_double_tap, (rsp_valid && (rsp_blink_request != 2'd0)) |-> (blink_consistent && rsp_is_calibrated), "blink request inconsistent")
   `TTL_ASSERT(a_uncalibrated_idle, (rsp_valid && !rsp_is_calibrated) |-> lamp_untouched, "lamp changed uncalibrated")

endmodule

`default_nettype wire

### verif/tb_touch_tap_lamp_controller.sv
// Self-checking testbench of the touch and tap lamp controller.
module tb_touch_tap_lamp_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import ttl_pkg::*;

   // Cycles without any accepted word before the run is declared hung
   localparam int QUIET_LIMIT = 2000;

   // One response word as the block should present it
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       lamp_on;
      logic       auto_on;
      logic [2:0] colour;
      logic [1:0] blink;
      logic       calibrated;
   } lamp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [31:0] req_now_ms       = '0;
   logic [15:0] req_touch_sample = '0;
   logic [9:0]  req_light_sample = '0;
   logic [9:0]  req_tap_sample   = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_level;
   logic [7:0]  rsp_green_level;
   logic [7:0]  rsp_blue_level;
   logic        rsp_lamp_on;
   logic        rsp_auto_on;
   logic [2:0]  rsp_colour_index;
   logic [1:0]  rsp_blink_request;
   logic        rsp_is_calibrated;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   touch_tap_lamp_controller uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_now_ms        (req_now_ms),
      .req_touch_sample  (req_touch_sample),
      .req_light_sample  (req_light_sample),
      .req_tap_sample    (req_tap_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red_level     (rsp_red_level),
      .rsp_green_level   (rsp_green_level),
      .rsp_blue_level    (rsp_blue_level),
      .rsp_lamp_on       (rsp_lamp_on),
      .rsp_auto_on       (rsp_auto_on),
      .rsp_colour_index  (rsp_colour_index),
      .rsp_blink_request (rsp_blink_request),
      .rsp_is_calibrated (rsp_is_calibrated),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 20 ns clock period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow of the lamp: register copy and the state the block should hold
   // ---------------------------------------------------------------------
   logic [31:0] lamp_regs [7];

   logic        lamp_is_on   = 1'b0;
   colour_type  colour_sel   = COLOUR_WHITE;
   logic        auto_mode    = 1'b0;
   logic        calib_seen   = 1'b0;
   logic        tap_armed    = 1'b0;
   logic [31:0] last_tap_at  = '0;
   logic [31:0] last_touch_at = '0;
   int          refresh_count = 0;
   logic [9:0]  tap_floor    = '0;
   logic [15:0] touch_floor  = '0;
   rgb_type     drive        = '0;

   lamp_word_type lamp_words_due [$];

   int          errors        = 0;
   int          quiet_cycles  = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic [31:0] tick_ms       = '0;

   initial begin
      lamp_regs[REG_TOUCH_THRESHOLD]  = 32'(TOUCH_THRESHOLD_RST);
      lamp_regs[REG_TAP_THRESHOLD]    = 32'(TAP_THRESHOLD_RST);
      lamp_regs[REG_LIGHT_THRESHOLD]  = 32'(LIGHT_THRESHOLD_RST);
      lamp_regs[REG_MAX_LEVEL]        = 32'(MAX_LEVEL_RST);
      lamp_regs[REG_TOUCH_HOLDOFF_MS] = 32'(TOUCH_HOLDOFF_MS_RST);
      lamp_regs[REG_DOUBLE_TAP_MS]    = 32'(DOUBLE_TAP_MS_RST);
      lamp_regs[REG_CALIB_WINDOW_MS]  = 32'(CALIB_WINDOW_MS_RST);
   end

   // Load the drive latch from the current colour; unused channels get 0.
   function automatic void load_drive(input logic [7:0] level);
      drive.red   = (colour_sel inside {COLOUR_WHITE, COLOUR_RED, COLOUR_YELLOW,
                                        COLOUR_MAGENTA}) ? level : 8'd0;
      drive.green = (colour_sel inside {COLOUR_WHITE, COLOUR_GREEN, COLOUR_YELLOW,
                                        COLOUR_CYAN}) ? level : 8'd0;
      drive.blue  = (colour_sel inside {COLOUR_WHITE, COLOUR_BLUE, COLOUR_CYAN,
                                        COLOUR_MAGENTA}) ? level : 8'd0;
   endfunction

   function automatic void switch_on(input logic [7:0] level);
      lamp_is_on = 1'b1;
      load_drive(level);
   endfunction

   function automatic void switch_off();
      lamp_is_on = 1'b0;
      drive      = '0;
   endfunction

   function automatic void step_colour(input logic [7:0] level);
      colour_sel = (colour_sel == COLOUR_MAGENTA) ? COLOUR_WHITE
                                                  : colour_type'(colour_sel + 3'd1);
      load_drive(level);
   endfunction

   // Apply one sensor tick to the shadow lamp and queue the word it yields.
   task automatic advance_lamp(input logic [31:0] now, input logic [15:0] touch,
                               input logic [9:0] light, input logic [9:0] tap);
      lamp_word_type w;
      logic [7:0] top;
      logic [7:0] level;
      logic [1:0] blink;
      top   = lamp_regs[REG_MAX_LEVEL][7:0];
      blink = 2'd0;

      // Below the window only the baselines move
      if (now < lamp_regs[REG_CALIB_WINDOW_MS]) begin
         if (tap > tap_floor) tap_floor = tap;
         if (touch > touch_floor) touch_floor = touch;
      end else begin
         calib_seen = 1'b1;
      end

      // Brightness band, saturating at zero for a low max level
      if (light <= LIGHT_BAND_LOW)
         level = (top >= LEVEL_DROP_LOW) ? top - LEVEL_DROP_LOW : 8'd0;
      else if (light <= LIGHT_BAND_MID)
         level = (top >= LEVEL_DROP_MID) ? top - LEVEL_DROP_MID : 8'd0;
      else
         level = top;

      if (calib_seen) begin
         // 32-bit context: baseline plus threshold cannot overflow
         if (touch > touch_floor + lamp_regs[REG_TOUCH_THRESHOLD] &&
             (now - last_touch_at) > lamp_regs[REG_TOUCH_HOLDOFF_MS]) begin
            if (lamp_is_on) switch_off();
            else            switch_on(level);
            last_touch_at = now;
         end

         if (tap > tap_floor + lamp_regs[REG_TAP_THRESHOLD]) begin
            if (tap_armed) begin
               tap_armed = 1'b0;
               if ((now - last_tap_at) < lamp_regs[REG_DOUBLE_TAP_MS]) begin
                  auto_mode = !auto_mode;
                  blink     = auto_mode ? 2'd2 : 2'd3;
                  switch_off();
               end else begin
                  step_colour(level);
               end
            end else begin
               tap_armed   = 1'b1;
               last_tap_at = now;
            end
         end

         // Pending tap runs out against the same tick's timestamp
         if (tap_armed && (now - last_tap_at) >= lamp_regs[REG_DOUBLE_TAP_MS]) begin
            tap_armed = 1'b0;
            step_colour(level);
         end

         if (auto_mode) begin
            if (light < lamp_regs[REG_LIGHT_THRESHOLD] && !lamp_is_on)
               switch_on(level);
            else if (light > lamp_regs[REG_LIGHT_THRESHOLD] && lamp_is_on)
               switch_off();
         end

         // Count saturates while off; the first tick on at the limit reloads
         if (refresh_count >= REFRESH_TICKS_DEF && lamp_is_on) begin
            load_drive(level);
            refresh_count = 0;
         end
         if (refresh_count < REFRESH_TICKS_DEF) refresh_count++;
      end

      w.red        = drive.red;
      w.green      = drive.green;
      w.blue       = drive.blue;
      w.lamp_on    = lamp_is_on;
      w.auto_on    = auto_mode;
      w.colour     = colour_sel;
      w.blink      = blink;
      w.calibrated = calib_seen;
      lamp_words_due.push_back(w);
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: sample both channels at the edge, check responses against the
   // oldest due word, advance the shadow lamp on every accepted request.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      lamp_word_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (lamp_words_due.size() == 0) begin
               $error("response word with no word due");
               errors++;
            end else begin
               due = lamp_words_due.pop_front();
               check_field("red_level",     due.red,        rsp_red_level);
               check_field("green_level",   due.green,      rsp_green_level);
               check_field("blue_level",    due.blue,       rsp_blue_level);
               check_field("lamp_on",       due.lamp_on,    rsp_lamp_on);
               check_field("auto_on",       due.auto_on,    rsp_auto_on);
               check_field("colour_index",  due.colour,     rsp_colour_index);
               check_field("blink_request", due.blink,      rsp_blink_request);
               check_field("is_calibrated", due.calibrated, rsp_is_calibrated);
            end
         end
         if (req_valid && req_ready)
            advance_lamp(req_now_ms, req_touch_sample, req_light_sample, req_tap_sample);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
      end
   end

   // Receiver: stall at random at the rate of the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Hang detector: nothing accepted for too long ends the run
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Send one tick word: idle at random, then hold valid until accepted.
   task automatic send_tick(input logic [31:0] now, input logic [15:0] touch,
                            input logic [9:0] light, input logic [9:0] tap);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      tick_ms          = now;
      req_valid        <= 1'b1;
      req_now_ms       <= now;
      req_touch_sample <= touch;
      req_light_sample <= light;
      req_tap_sample   <= tap;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every due word has come back.
   task automatic drain_words();
      req_valid <= 1'b0;
      while (lamp_words_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup then access phase; psel stays high so writes can run back to back.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      lamp_regs[idx] = value;
   endtask

   task automatic read_check(input csr_index_type idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata != lamp_regs[idx]) begin
         $error("register %s expected %0d actual %0d", idx.name(), lamp_regs[idx], prdata);
         errors++;
      end
   endtask

   task automatic bus_idle();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic read_all_regs();
      for (int i = 0; i < 7; i++) read_check(csr_index_type'(i));
      bus_idle();
   endtask

   // Write all seven registers, then read every one back.
   task automatic apply_settings(input logic [15:0] touch_thr, input logic [9:0] tap_thr,
                                 input logic [9:0] light_thr, input logic [7:0] top,
                                 input logic [15:0] holdoff, input logic [15:0] dbl_tap,
                                 input logic [15:0] window);
      write_reg(REG_TOUCH_THRESHOLD,  32'(touch_thr));
      write_reg(REG_TAP_THRESHOLD,    32'(tap_thr));
      write_reg(REG_LIGHT_THRESHOLD,  32'(light_thr));
      write_reg(REG_MAX_LEVEL,        32'(top));
      write_reg(REG_TOUCH_HOLDOFF_MS, 32'(holdoff));
      write_reg(REG_DOUBLE_TAP_MS,    32'(dbl_tap));
      write_reg(REG_CALIB_WINDOW_MS,  32'(window));
      read_all_regs();
   endtask

   // ---------------------------------------------------------------------
   // Directed tests, all at reset settings: touch 60, tap 4, light 700,
   // max 150, holdoff 500, double tap 500, window 2000
   // ---------------------------------------------------------------------
   task automatic test_register_defaults();
      read_all_regs();
   endtask

   // Baselines track running maxima below the window; reaching it calibrates.
   task automatic test_calibration();
      send_tick(32'd0,    16'd0,   10'd0,    10'd0);
      send_tick(32'd100,  16'd800, 10'd600,  10'd20);
      send_tick(32'd1999, 16'd500, 10'd1023, 10'd10);
      send_tick(32'd2000, 16'd800, 10'd750,  10'd20);
   endtask

   // Touch equal to baseline plus threshold is ignored, above it toggles,
   // and a second touch inside the holdoff is dropped.
   task automatic test_touch_toggle();
      send_tick(32'd2100, 16'd860,   10'd591, 10'd0);
      send_tick(32'd2600, 16'd861,   10'd591, 10'd0);
      send_tick(32'd2700, 16'hFFFF,  10'd300, 10'd0);
      send_tick(32'd3101, 16'hFFFF,  10'd751, 10'd0);
      send_tick(32'd3700, 16'hFFFF,  10'd751, 10'd0);
   endtask

   // Single tap expiring into a colour step, then a double tap into auto mode.
   task automatic test_taps();
      send_tick(32'd3800, 16'd0, 10'd751,  10'd24);
      send_tick(32'd3900, 16'd0, 10'd751,  10'd25);
      send_tick(32'd4000, 16'd0, 10'd751,  10'd0);
      send_tick(32'd4400, 16'd0, 10'd751,  10'd0);
      send_tick(32'd4500, 16'd0, 10'd1023, 10'd1023);
      send_tick(32'd4600, 16'd0, 10'd1023, 10'd1023);
   endtask

   // Auto mode: equal light holds, dark switches on, bright switches off,
   // then a double tap leaves auto mode again.
   task automatic test_auto_light();
      send_tick(32'd4700, 16'd0, 10'd700, 10'd0);
      send_tick(32'd4800, 16'd0, 10'd0,   10'd0);
      send_tick(32'd4900, 16'd0, 10'd701, 10'd0);
      send_tick(32'd5000, 16'd0, 10'd699, 10'd0);
      send_tick(32'd5100, 16'd0, 10'd699, 10'd600);
      send_tick(32'd5200, 16'd0, 10'd699, 10'd600);
   endtask

   // Timestamp wraps back into the window: baselines move, calibration holds.
   task automatic test_timestamp_wrap();
      send_tick(32'hFFFF_FFFF, 16'd0,   10'd512, 10'd0);
      send_tick(32'd5,         16'd900, 10'd300, 10'd30);
      send_tick(32'd3000,      16'd961, 10'd800, 10'd35);
   endtask

   // ---------------------------------------------------------------------
   // Random ticks shaped around the shadow baselines and thresholds
   // ---------------------------------------------------------------------
   task automatic run_random_ticks(input int count);
      int          roll;
      logic [31:0] now;
      logic [31:0] touch_edge;
      logic [31:0] tap_edge;
      logic [15:0] touch_v;
      logic [9:0]  light_v;
      logic [9:0]  tap_v;
      logic [9:0]  lt;
      for (int n = 0; n < count; n++) begin
         // Advance time: mostly short steps, some on the holdoff and
         // double-tap edges, some long jumps and wraps
         now  = tick_ms;
         roll = $urandom_range(0, 99);
         if (roll < 55)      now = now + $urandom_range(1, 200);
         else if (roll < 65) now = now + lamp_regs[REG_TOUCH_HOLDOFF_MS] + $urandom_range(0, 2) - 1;
         else if (roll < 75) now = now + lamp_regs[REG_DOUBLE_TAP_MS] + $urandom_range(0, 2) - 1;
         else if (roll < 90) now = now + $urandom_range(200, 3000);
         else if (roll < 97) now = now + $urandom_range(3000, 200000);
         else if (roll < 99) now = 32'hFFFF_FFFF - $urandom_range(0, 300);
         else if ($urandom_range(0, 1) == 0) now = $urandom();
         else now = $urandom_range(0, lamp_regs[REG_CALIB_WINDOW_MS]);

         touch_edge = touch_floor + lamp_regs[REG_TOUCH_THRESHOLD];
         tap_edge   = tap_floor + lamp_regs[REG_TAP_THRESHOLD];

         if (now < lamp_regs[REG_CALIB_WINDOW_MS]) begin
            // Keep baselines low so touches and taps stay reachable
            touch_v = 16'($urandom_range(0, 1500));
            tap_v   = 10'($urandom_range(0, 60));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 6 && touch_edge < 32'hFFFF)
               touch_v = 16'($urandom_range(32'hFFFF, touch_edge + 1));
            else if (roll < 9 && touch_edge <= 32'hFFFF) touch_v = touch_edge[15:0];
            else if (roll < 11) touch_v = 16'hFFFF;
            else if (roll < 15) touch_v = 16'($urandom());
            else                touch_v = 16'($urandom_range(0, touch_floor));

            roll = $urandom_range(0, 99);
            if (roll < 15 && tap_edge < 32'd1023)
               tap_v = 10'($urandom_range(1023, tap_edge + 1));
            else if (roll < 19 && tap_edge <= 32'd1023) tap_v = tap_edge[9:0];
            else if (roll < 22) tap_v = 10'h3FF;
            else if (roll < 26) tap_v = 10'($urandom());
            else                tap_v = 10'($urandom_range(0, tap_floor));
         end

         // Light: 45 percent uniform, the rest on the band and threshold edges
         lt = lamp_regs[REG_LIGHT_THRESHOLD][9:0];
         if ($urandom_range(0, 99) < 45) begin
            light_v = 10'($urandom_range(0, 1023));
         end else begin
            case ($urandom_range(0, 8))
               0:       light_v = 10'd0;
               1:       light_v = LIGHT_BAND_LOW;
               2:       light_v = LIGHT_BAND_LOW + 10'd1;
               3:       light_v = LIGHT_BAND_MID;
               4:       light_v = LIGHT_BAND_MID + 10'd1;
               5:       light_v = 10'd1023;
               6:       light_v = lt - 10'd1;
               7:       light_v = lt;
               default: light_v = lt + 10'd1;
            endcase
         end

         send_tick(now, touch_v, light_v, tap_v);
      end
   endtask

   // Several register settings, each run under one idling pattern.
   task automatic test_random_settings();
      for (int chunk = 0; chunk < 8; chunk++) begin
         drain_words();
         case (chunk)
            0: apply_settings(TOUCH_THRESHOLD_RST, TAP_THRESHOLD_RST, LIGHT_THRESHOLD_RST,
                              MAX_LEVEL_RST, TOUCH_HOLDOFF_MS_RST, DOUBLE_TAP_MS_RST,
                              CALIB_WINDOW_MS_RST);
            1: apply_settings(16'd0, 10'd0, 10'd0, 8'd0, 16'd0, 16'd0, 16'd0);
            2: apply_settings(16'hFFFF, 10'h3FF, 10'h3FF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: apply_settings(16'd200, 10'd30, 10'd400, 8'd60, 16'd150, 16'd300, 16'd1000);
            5: apply_settings(16'd100, 10'd8, 10'd590, 8'd100, 16'hFFFF, 16'd0, 16'd500);
            7: apply_settings(16'd1, 10'd1, 10'd1023, 8'd255, 16'd1, 16'd1, 16'd0);
            default:
               apply_settings(16'($urandom_range(0, 2000)), 10'($urandom_range(0, 50)),
                              10'($urandom_range(0, 1023)), 8'($urandom_range(100, 255)),
                              16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
                              16'($urandom_range(0, 3000)));
         endcase
         case (chunk % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         run_random_ticks(115);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      // Hold reset at the start, release it once
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_defaults();
      test_calibration();
      test_touch_toggle();
      test_taps();
      test_auto_light();
      test_timestamp_wrap();
      test_random_settings();

      // Let the last word drain, then a short tail for stray responses
      send_idle_pct  = 0;
      drain_words();
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);

      if (errors == 0 && lamp_words_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/ttl_pkg.sv
hdl/touch_tap_lamp_controller.sv
verif/tb_touch_tap_lamp_controller.sv
